@@ src/aac_pkg.sv @@
// shared types and constants for the accelerometer axis conditioner
package aac_pkg;

	localparam int AXIS_W   = 2;
	localparam int SAMPLE_W = 16;

	typedef logic [AXIS_W-1:0]   axis_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	// axis codes
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

endpackage

@@ src/aac_sample_if.sv @@
// valid/ready channel carrying one tagged input sample
interface aac_sample_if;
	import aac_pkg::*;

	logic    valid;
	logic    ready;
	axis_t   axis;
	sample_t sample;

	modport source (output valid, output axis, output sample, input ready);
	modport sink (input valid, input axis, input sample, output ready);

endinterface

@@ src/aac_result_if.sv @@
// valid/ready channel carrying one conditioned result
interface aac_result_if;
	import aac_pkg::*;

	logic    valid;
	logic    ready;
	axis_t   axis_out;
	sample_t value;

	modport source (output valid, output axis_out, output value, input ready);
	modport sink (input valid, input axis_out, input value, output ready);

endinterface

@@ src/aac_ram.sv @@
// generic single-port-write, single-port-read ram with registered read-first output
module aac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents when both ports hit one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/accel_axis_conditioner_unit.sv @@
// accelerometer axis conditioner: x pass-through, y first difference, z moving average
// pipeline: stage 1 (ram read), stage 2 (sum update), then divide into the output register
// throughput: one sample per cycle while results are taken; the running sum register is updated
//   once per z sample in stage 1 from the ring ram's registered read of the slot being replaced
// reset: previous y, window fill, oldest slot, running sum and all stage valids clear;
//   the ring ram is not cleared, only slots already written are ever used
module accel_axis_conditioner_unit #(
	parameter int WINDOW = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	aac_sample_if.sink   samples,
	aac_result_if.source results
);
	import aac_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);
	// reciprocal for exact division of a 16-bit sum by the window length
	localparam logic [31:0] RECIP =
		32'((((64'd1 << 32) + 64'(WINDOW)) - 64'd1) / 64'(WINDOW));

	// ring control state
	logic [FW-1:0]  fill_q;
	logic [AW-1:0]  oldest_q;
	sample_t        prev_y_q;
	sample_t        sum_q;

	// stage 1
	logic           v_s1;
	logic           z_s1;
	logic           full_s1;
	logic           emit_s1;
	axis_t          axis_s1;
	sample_t        sample_s1;
	sample_t        value_s1;

	// stage 2
	logic           v_s2;
	logic           z_s2;
	axis_t          axis_s2;
	sample_t        value_s2;
	sample_t        sum_s2;

	// output register
	logic           out_v_q;
	axis_t          out_axis_q;
	sample_t        out_value_q;

	logic           rdy_out, rdy_s2, rdy_s1;
	logic           accept;
	logic           is_z, is_y, is_x;
	logic           full;
	logic [AW-1:0]  waddr;
	sample_t        ram_rdata;
	sample_t        sum_next;
	logic [47:0]    product;

	// stage-by-stage flow control
	assign rdy_out       = !out_v_q || results.ready;
	assign rdy_s2        = !v_s2 || rdy_out;
	assign rdy_s1        = !v_s1 || rdy_s2;
	assign samples.ready = rdy_s1;
	assign accept        = samples.valid && rdy_s1;

	assign is_x  = (samples.axis == AXIS_X);
	assign is_y  = (samples.axis == AXIS_Y);
	assign is_z  = (samples.axis == AXIS_Z);
	assign full  = (fill_q == FW'(WINDOW));
	assign waddr = full ? oldest_q : fill_q[AW-1:0];

	// ring storage: read the slot being replaced while the new sample is written
	aac_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (accept && is_z),
		.waddr (waddr),
		.wdata (samples.sample),
		.re    (accept && is_z),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	// ring pointers and previous y, updated on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			oldest_q <= '0;
			prev_y_q <= '0;
		end else if (accept) begin
			if (is_y) begin
				prev_y_q <= samples.sample;
			end
			if (is_z) begin
				if (!full) begin
					fill_q <= fill_q + FW'(1);
				end else if (oldest_q == AW'(WINDOW - 1)) begin
					oldest_q <= '0;
				end else begin
					oldest_q <= oldest_q + AW'(1);
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= accept && (is_x || is_y || is_z);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			z_s1      <= is_z;
			full_s1   <= full;
			emit_s1   <= !is_z || full || (fill_q == FW'(WINDOW - 1));
			axis_s1   <= samples.axis;
			sample_s1 <= samples.sample;
			value_s1  <= is_y ? (prev_y_q - samples.sample) : samples.sample;
		end
	end

	// running sum: drop the replaced sample once the window is full
	assign sum_next = full_s1 ? (sum_q - ram_rdata + sample_s1) : (sum_q + sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v_s2  <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1 && emit_s1;
			if (v_s1 && z_s1) begin
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			z_s2     <= z_s1;
			axis_s2  <= axis_s1;
			value_s2 <= value_s1;
			sum_s2   <= sum_next;
		end
	end

	// mean by reciprocal multiply, exact for 16-bit sums
	assign product = 48'(sum_s2) * 48'(RECIP);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s2) begin
			out_axis_q  <= axis_s2;
			out_value_q <= z_s2 ? product[47:32] : value_s2;
		end
	end

	assign results.valid    = out_v_q;
	assign results.axis_out = out_axis_q;
	assign results.value    = out_value_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW))
		else $error("window fill count beyond window length");

	a_oldest_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q != '0) |-> full)
		else $error("oldest slot moved before window filled");

	a_no_result_for_bad_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_axis_q == AXIS_X || out_axis_q == AXIS_Y || out_axis_q == AXIS_Z))
		else $error("result carries an unused axis code");

	a_sum_moves_only_on_z: assert property (@(posedge clk) disable iff (!arst_n)
		!(rdy_s2 && v_s1 && z_s1) |=> $stable(sum_q))
		else $error("running sum changed without a z sample");

endmodule
